@@ design/ntc_beta_temperature_defines.svh @@
// Assertion macros shared by the thermistor temperature block.
`ifndef NTC_BETA_TEMPERATURE_DEFINES_SVH
`define NTC_BETA_TEMPERATURE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define NTCBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define NTCBT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ntcbt_pkg.sv @@
// Types and constants of the NTC thermistor temperature block.
package ntcbt_pkg;

    localparam int ADC_BITS_DEFAULT = 10;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [15:0] SERIES_RESET  = 16'd10000;
    localparam logic [15:0] NOMINAL_RESET = 16'd10000;
    localparam logic [15:0] BETA_RESET    = 16'd3950;
    localparam logic [7:0]  T0_RESET      = 8'd25;
    localparam logic [7:0]  FAULT_RESET   = 8'd255;

    localparam logic [31:0] LN2_Q32        = 32'hB17217F8;
    localparam logic [16:0] KELVIN_X100    = 17'd27315;
    localparam logic [7:0]  TEMP_MAX       = 8'd254;
    localparam int          LOG_FRAC_BITS  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SERIES  = 3'd0,
        REG_NOMINAL = 3'd1,
        REG_BETA    = 3'd2,
        REG_T0      = 3'd3,
        REG_FAULT   = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_R,
        S_CHK_R,
        S_LOG_NORM,
        S_LOG_SQ,
        S_LOG_ADJ,
        S_LOG_END,
        S_LN_MUL,
        S_LOAD_Q,
        S_DIV_Q,
        S_LOAD_INV0,
        S_DIV_INV0,
        S_SUM,
        S_DIV_K,
        S_CHK_K,
        S_DIV_C
    } state_t;

endpackage

@@ design/ntc_beta_temperature.sv @@
// NTC thermistor temperature from a divider reading by the B-parameter equation.
//
//  port group        direction  handshake
//  adc_code          in         start while busy is low
//  temperature_c,    out        done, one cycle, no back pressure
//    sensor_fault
//  cfg_index/data    in         cfg_we, taken at once
//
// A short or open reading answers in the cycle after start. Any other item keeps busy
// high through the divide and log states, whose run depends on DW = max(ADC_BITS+32, 40)
// and on the normalizing shifts of the two logs; the degenerate cases finish earlier.
// The one-bit-per-cycle restoring divider and the two 24-step log2 loops
// set that run. busy is high from start and is low again in the cycle of done.
// Reset is asynchronous and restores the register defaults; no memory is cleared.
`include "ntc_beta_temperature_defines.svh"

module ntc_beta_temperature #(
    parameter int ADC_BITS = ntcbt_pkg::ADC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ADC_BITS-1:0]                adc_code,
    input  logic                               cfg_we,
    input  logic [ntcbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ntcbt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                               done,
    output logic [7:0]                         temperature_c,
    output logic                               sensor_fault
);
    import ntcbt_pkg::*;

    localparam int RW = ADC_BITS + 32;
    localparam int DW = (RW > 40) ? RW : 40;
    localparam int CW = $clog2(DW);
    localparam int SW = $clog2(RW);
    localparam int PW = 16 + ADC_BITS;
    localparam logic [7:0] INT_BASE = 8'(RW - 17);
    localparam logic [DW-1:0] HUNDRED_Q32 = DW'(64'd100 << 32);

    state_t state_reg, state_next;

    logic [15:0] rs_reg, r0_reg, beta_reg;
    logic [7:0]  t0_reg, fcode_reg;

    logic [DW-1:0]     quo_reg, quo_next, rem_reg, rem_next, den_reg, den_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [RW-1:0]     xn_reg, xn_next;
    logic [SW-1:0]     sh_reg, sh_next;
    logic [31:0]       m_reg, m_next, mag_reg, mag_next;
    logic [23:0]       frac_reg, frac_next;
    logic [63:0]       prod_reg, prod_next;
    logic              second_reg, second_next, neg_reg, neg_next;
    logic signed [31:0] lr_reg, lr_next;
    logic [39:0]       q_reg, q_next;
    logic [7:0]        temp_reg, temp_next;
    logic              fault_reg, fault_next, done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg    <= SERIES_RESET;
            r0_reg    <= NOMINAL_RESET;
            beta_reg  <= BETA_RESET;
            t0_reg    <= T0_RESET;
            fcode_reg <= FAULT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SERIES:  rs_reg    <= cfg_data;
                REG_NOMINAL: r0_reg    <= cfg_data;
                REG_BETA:    beta_reg  <= cfg_data;
                REG_T0:      t0_reg    <= cfg_data[7:0];
                REG_FAULT:   fcode_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            fault_reg <= 1'b0;
            temp_reg  <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            fault_reg <= fault_next;
            temp_reg  <= temp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        cnt_reg    <= cnt_next;
        xn_reg     <= xn_next;
        sh_reg     <= sh_next;
        m_reg      <= m_next;
        mag_reg    <= mag_next;
        frac_reg   <= frac_next;
        prod_reg   <= prod_next;
        second_reg <= second_next;
        neg_reg    <= neg_next;
        lr_reg     <= lr_next;
        q_reg      <= q_next;
    end

    always_comb
    begin
        logic [DW:0]        shifted;
        logic [DW:0]        diff;
        logic               ge;
        logic               div_last;
        logic               is_fault;
        logic [PW-1:0]      rc;
        logic [32:0]        sq;
        logic signed [31:0] lval;
        logic signed [31:0] d;
        logic [41:0]        invt;
        logic [31:0]        mul_a, mul_b;

        state_next  = state_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        cnt_next    = cnt_reg;
        xn_next     = xn_reg;
        sh_next     = sh_reg;
        m_next      = m_reg;
        mag_next    = mag_reg;
        frac_next   = frac_reg;
        prod_next   = prod_reg;
        second_next = second_reg;
        neg_next    = neg_reg;
        lr_next     = lr_reg;
        q_next      = q_reg;
        temp_next   = temp_reg;
        fault_next  = fault_reg;
        done_next   = 1'b0;

        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = ~diff[DW];
        div_last = (cnt_reg == CW'(DW - 1));
        is_fault = (adc_code == '0) || (&adc_code);
        rc       = PW'(rs_reg) * PW'(adc_code);
        sq       = prod_reg[63:31];
        lval     = {INT_BASE - 8'(sh_reg), frac_reg};
        d        = lr_reg - lval;
        invt     = neg_reg ? ({2'b00, quo_reg[39:0]} - {2'b00, q_reg})
                           : ({2'b00, quo_reg[39:0]} + {2'b00, q_reg});

        // The multiplier squares the log mantissa or scales by ln 2.
        if (state_reg == S_LOG_SQ)
        begin
            mul_a = m_reg;
            mul_b = m_reg;
        end
        else
        begin
            mul_a = mag_reg;
            mul_b = LN2_Q32;
        end

        // One restoring divide step per cycle in every divide state.
        if (state_reg == S_DIV_R || state_reg == S_DIV_Q || state_reg == S_DIV_INV0 ||
            state_reg == S_DIV_K || state_reg == S_DIV_C)
        begin
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (is_fault)
                    begin
                        temp_next  = fcode_reg;
                        fault_next = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        quo_next   = DW'({rc, 16'b0});
                        rem_next   = '0;
                        den_next   = DW'({1'b1, {ADC_BITS{1'b0}}} - {1'b0, adc_code});
                        cnt_next   = '0;
                        state_next = S_DIV_R;
                    end
                end
            end
            S_DIV_R:
            begin
                if (div_last)
                    state_next = S_CHK_R;
            end
            S_CHK_R:
            begin
                if (quo_reg == '0 || r0_reg == '0 || beta_reg == '0)
                begin
                    temp_next  = 8'd0;
                    fault_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    xn_next     = quo_reg[RW-1:0];
                    sh_next     = '0;
                    frac_next   = '0;
                    second_next = 1'b0;
                    state_next  = S_LOG_NORM;
                end
            end
            S_LOG_NORM:
            begin
                if (xn_reg[RW-1])
                begin
                    m_next     = xn_reg[RW-1 -: 32];
                    cnt_next   = '0;
                    state_next = S_LOG_SQ;
                end
                else
                begin
                    xn_next = {xn_reg[RW-2:0], 1'b0};
                    sh_next = sh_reg + SW'(1);
                end
            end
            S_LOG_SQ:
            begin
                prod_next  = 64'(mul_a) * 64'(mul_b);
                state_next = S_LOG_ADJ;
            end
            S_LOG_ADJ:
            begin
                if (sq[32])
                    m_next = sq[32:1];
                else
                    m_next = sq[31:0];
                frac_next = {frac_reg[22:0], sq[32]};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(LOG_FRAC_BITS - 1))
                    state_next = S_LOG_END;
                else
                    state_next = S_LOG_SQ;
            end
            S_LOG_END:
            begin
                if (!second_reg)
                begin
                    lr_next     = lval;
                    xn_next     = RW'({r0_reg, 16'b0});
                    sh_next     = '0;
                    frac_next   = '0;
                    second_next = 1'b1;
                    state_next  = S_LOG_NORM;
                end
                else
                begin
                    neg_next   = d[31];
                    mag_next   = d[31] ? 32'(-d) : 32'(d);
                    state_next = S_LN_MUL;
                end
            end
            S_LN_MUL:
            begin
                prod_next  = 64'(mul_a) * 64'(mul_b);
                state_next = S_LOAD_Q;
            end
            S_LOAD_Q:
            begin
                quo_next   = DW'({prod_reg[63:32], 8'b0});
                rem_next   = '0;
                den_next   = DW'(beta_reg);
                cnt_next   = '0;
                state_next = S_DIV_Q;
            end
            S_DIV_Q:
            begin
                if (div_last)
                    state_next = S_LOAD_INV0;
            end
            S_LOAD_INV0:
            begin
                q_next     = quo_reg[39:0];
                quo_next   = HUNDRED_Q32;
                rem_next   = '0;
                den_next   = DW'(17'(t0_reg) * 17'd100 + KELVIN_X100);
                cnt_next   = '0;
                state_next = S_DIV_INV0;
            end
            S_DIV_INV0:
            begin
                if (div_last)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                if (invt[41] || invt == '0)
                begin
                    // Negative sum means below 0 K; zero means unbounded.
                    temp_next  = invt[41] ? 8'd0 : TEMP_MAX;
                    fault_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    quo_next   = HUNDRED_Q32;
                    rem_next   = '0;
                    den_next   = DW'(invt[39:0]);
                    cnt_next   = '0;
                    state_next = S_DIV_K;
                end
            end
            S_DIV_K:
            begin
                if (div_last)
                    state_next = S_CHK_K;
            end
            S_CHK_K:
            begin
                if (quo_reg < DW'(KELVIN_X100))
                begin
                    temp_next  = 8'd0;
                    fault_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    quo_next   = quo_reg - DW'(KELVIN_X100);
                    rem_next   = '0;
                    den_next   = DW'(100);
                    cnt_next   = '0;
                    state_next = S_DIV_C;
                end
            end
            S_DIV_C:
            begin
                if (div_last)
                begin
                    temp_next  = (quo_next > DW'(TEMP_MAX)) ? TEMP_MAX : quo_next[7:0];
                    fault_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign temperature_c = temp_reg;
    assign sensor_fault  = fault_reg;

    `NTCBT_ASSERT(a_done_when_idle, done |-> !busy, "result strobe while busy")
    `NTCBT_ASSERT(a_fault_fast,
        (start && !busy && (adc_code == '0 || (&adc_code))) |=> (done && sensor_fault),
        "short or open reading not answered at once")
    `NTCBT_ASSERT(a_temp_range, (done && !sensor_fault) |-> (temperature_c <= TEMP_MAX),
        "temperature beyond saturation limit")
    `NTCBT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!done && !busy),
        "activity during reset")

endmodule
